/* sv/epoch_to_utc_date_defines.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef EPOCH_TO_UTC_DATE_DEFINES_SVH
`define EPOCH_TO_UTC_DATE_DEFINES_SVH

// property checked only while reset is released
`define E2U_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("e2u check failed");

// property checked on every edge, reset included
`define E2U_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("e2u reset check failed");

`endif

/* sv/e2u_pkg.sv */
// shared widths, constants, types and the month length table
// for the epoch to utc date converter; no dependencies
package e2u_pkg;

    localparam int SECONDS_WIDTH = 33;
    // 86400 > 2^16, so the day count fits in SECONDS_WIDTH - 16 bits
    localparam int DAYS_W  = SECONDS_WIDTH - 16;
    localparam int SOD_W   = 17;
    localparam int YEAR_W  = 12;

    // 86400 = 675 << 7, so days = (secs >> 7) / 675, taken by a reciprocal multiply
    // the rounding error of the reciprocal stays below 2^10, which keeps it exact
    localparam int DAY_POW2    = 7;
    localparam int QX_W        = SECONDS_WIDTH - DAY_POW2;
    localparam int RECIP_SHIFT = QX_W + 10;
    localparam int RECIP_W     = RECIP_SHIFT - 9;
    localparam int PROD_W      = QX_W + RECIP_W;
    localparam int BASE_W      = DAYS_W + SOD_W + 1;

    localparam logic [RECIP_W-1:0] DAY_RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd675 + 64'd1);

    localparam logic [SOD_W:0]    SECS_PER_DAY  = (SOD_W+1)'(86400);
    localparam logic [SOD_W-1:0]  SECS_PER_HOUR = SOD_W'(3600);
    localparam logic [SOD_W-1:0]  SECS_PER_MIN  = SOD_W'(60);
    localparam logic [YEAR_W-1:0] BASE_YEAR     = YEAR_W'(1970);

    // 1970 position in the 4, 100 and 400 year cycles
    localparam logic [1:0] BASE_Y4   = 2'd2;
    localparam logic [6:0] BASE_Y100 = 7'd70;
    localparam logic [8:0] BASE_Y400 = 9'd370;

    localparam logic [3:0] MON_FEB = 4'd1;
    localparam logic [3:0] MON_DEC = 4'd11;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_REM,
        S_HOUR,
        S_MIN,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                     valid;
        logic [SECONDS_WIDTH-1:0] secs;
    } t_req;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
    } t_date;

    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
        logic [4:0] d;
        case (mon)
            MON_FEB:                  d = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:  d = 5'd30;
            default:                  d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

/* sv/e2u_front.sv */
// input side: two-entry request queue between the port and the converter
// depends on e2u_pkg
module e2u_front import e2u_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [SECONDS_WIDTH-1:0] i_epoch_seconds,
    output t_req                     o_req,
    input  logic                     i_pop
);

    logic [SECONDS_WIDTH-1:0] r_mem [2];
    logic                     r_wptr;
    logic                     r_rptr;
    logic [1:0]               r_count;
    logic                     push;
    logic                     pop;

    assign o_ready     = (r_count != 2'd2);
    assign push        = i_valid && o_ready;
    assign pop         = i_pop && (r_count != 2'd0);
    assign o_req.valid = (r_count != 2'd0);
    assign o_req.secs  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_epoch_seconds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

endmodule

/* sv/e2u_back.sv */
// converter sequencer: reciprocal divide by 86400, then hour, minute,
// year and month walks, then the output register; depends on e2u_pkg
module e2u_back import e2u_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_ready,
    output t_date o_date
);

    t_state r_state, n_state;

    logic [SECONDS_WIDTH-1:0] r_div,   n_div;
    logic [SOD_W-1:0]         r_rem,   n_rem;
    logic [DAYS_W-1:0]        r_days,  n_days;
    logic [4:0]               r_hour,  n_hour;
    logic [5:0]               r_min,   n_min;
    logic [5:0]               r_sec,   n_sec;
    logic [YEAR_W-1:0]        r_year,  n_year;
    logic [1:0]               r_y4,    n_y4;
    logic [6:0]               r_y100,  n_y100;
    logic [8:0]               r_y400,  n_y400;
    logic [3:0]               r_mon,   n_mon;
    logic                     r_out_valid;
    t_date                    r_out;

    logic [PROD_W-1:0] day_prod;
    logic [BASE_W-1:0] day_base;
    logic              leap;
    logic [8:0]        diy;
    logic [4:0]        dim;
    logic              year_step;
    logic              month_step;
    logic              out_free;
    logic              load_out;

    assign day_prod   = PROD_W'(r_div[SECONDS_WIDTH-1:DAY_POW2]) * PROD_W'(DAY_RECIP);
    assign day_base   = BASE_W'(r_days) * BASE_W'(SECS_PER_DAY);
    assign leap       = (r_y4 == 2'd0) && ((r_y100 != 7'd0) || (r_y400 == 9'd0));
    assign diy        = leap ? 9'd366 : 9'd365;
    assign dim        = month_days(r_mon, leap);
    assign year_step  = (r_days >= DAYS_W'(diy));
    assign month_step = (r_days >= DAYS_W'(dim)) && (r_mon != MON_DEC);
    assign out_free   = !r_out_valid || i_ready;
    assign load_out   = (r_state == S_DONE) && out_free;
    assign o_pop      = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_date     = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_req.valid) n_state = S_DIV;
            S_DIV:   n_state = S_REM;
            S_REM:   n_state = S_HOUR;
            S_HOUR:  if (r_rem < SECS_PER_HOUR) n_state = S_MIN;
            S_MIN:   if (r_rem < SECS_PER_MIN) n_state = S_YEAR;
            S_YEAR:  if (!year_step) n_state = S_MONTH;
            S_MONTH: if (!month_step) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath updates per state
    always_comb begin
        n_div  = r_div;
        n_rem  = r_rem;
        n_days = r_days;
        n_hour = r_hour;
        n_min  = r_min;
        n_sec  = r_sec;
        n_year = r_year;
        n_y4   = r_y4;
        n_y100 = r_y100;
        n_y400 = r_y400;
        n_mon  = r_mon;
        case (r_state)
            S_IDLE: begin
                n_div  = i_req.secs;
                n_rem  = '0;
                n_hour = '0;
                n_min  = '0;
                n_year = BASE_YEAR;
                n_y4   = BASE_Y4;
                n_y100 = BASE_Y100;
                n_y400 = BASE_Y400;
                n_mon  = '0;
            end
            S_DIV: begin
                n_days = day_prod[PROD_W-1:RECIP_SHIFT];
            end
            S_REM: begin
                // seconds within the day
                n_rem = SOD_W'(r_div - SECONDS_WIDTH'(day_base));
            end
            S_HOUR: begin
                if (r_rem >= SECS_PER_HOUR) begin
                    n_rem  = r_rem - SECS_PER_HOUR;
                    n_hour = r_hour + 5'd1;
                end
            end
            S_MIN: begin
                if (r_rem >= SECS_PER_MIN) begin
                    n_rem = r_rem - SECS_PER_MIN;
                    n_min = r_min + 6'd1;
                end else begin
                    n_sec = r_rem[5:0];
                end
            end
            S_YEAR: begin
                if (year_step) begin
                    n_days = r_days - DAYS_W'(diy);
                    n_year = r_year + YEAR_W'(1);
                    n_y4   = r_y4 + 2'd1;
                    n_y100 = (r_y100 == 7'd99)  ? 7'd0 : r_y100 + 7'd1;
                    n_y400 = (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                end
            end
            S_MONTH: begin
                if (month_step) begin
                    n_days = r_days - DAYS_W'(dim);
                    n_mon  = r_mon + 4'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_days <= n_days;
        r_hour <= n_hour;
        r_min  <= n_min;
        r_sec  <= n_sec;
        r_year <= n_year;
        r_y4   <= n_y4;
        r_y100 <= n_y100;
        r_y400 <= n_y400;
        r_mon  <= n_mon;
        if (load_out) begin
            r_out.year   <= r_year;
            r_out.month  <= r_mon + 4'd1;
            r_out.day    <= 5'(r_days) + 5'd1;
            r_out.hour   <= r_hour;
            r_out.minute <= r_min;
            r_out.second <= r_sec;
        end
    end

endmodule

/* sv/epoch_to_utc_date.sv */
// from accept to result the sequencer runs the divide and remainder steps, then walks hours,
// minutes, whole years since 1970 and whole months; the walks set how long it takes
// the sequencer converts one item at a time; a two-entry queue takes new items meanwhile
// reset: synchronous active low, empties the queue and drops any pending result
// top level: queue front end, conversion sequencer, output ports
// depends on e2u_pkg, e2u_front, e2u_back
module epoch_to_utc_date import e2u_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [SECONDS_WIDTH-1:0] i_epoch_seconds,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [YEAR_W-1:0]        o_year,
    output logic [3:0]               o_month,
    output logic [4:0]               o_day,
    output logic [4:0]               o_hour,
    output logic [5:0]               o_minute,
    output logic [5:0]               o_second
);

    t_req  req;
    logic  pop;
    t_date date;

    e2u_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_epoch_seconds (i_epoch_seconds),
        .o_req           (req),
        .i_pop           (pop)
    );

    e2u_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_date  (date)
    );

    assign o_year   = date.year;
    assign o_month  = date.month;
    assign o_day    = date.day;
    assign o_hour   = date.hour;
    assign o_minute = date.minute;
    assign o_second = date.second;

endmodule

/* sv/e2u_checker.sv */
// port-level checks for the epoch to utc date converter, bound to the top level
// depends on e2u_pkg and epoch_to_utc_date_defines.svh
`include "epoch_to_utc_date_defines.svh"

module e2u_checker import e2u_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic [SECONDS_WIDTH-1:0] i_epoch_seconds,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic [YEAR_W-1:0]        o_year,
    input logic [3:0]               o_month,
    input logic [4:0]               o_day,
    input logic [4:0]               o_hour,
    input logic [5:0]               o_minute,
    input logic [5:0]               o_second
);

    // a stalled result holds
    `E2U_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable({o_year, o_month, o_day, o_hour, o_minute, o_second}))

    // every delivered date and time of day is a legal one
    `E2U_ASSERT(a_fields_legal, i_clk, i_rst_n, o_valid |-> o_month >= 4'd1 && o_month <= 4'd12 && o_day >= 5'd1 && o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59 && o_year >= BASE_YEAR)

    // day never passes 29 in February or 30 in April, June, September or November
    `E2U_ASSERT(a_day_fits, i_clk, i_rst_n, o_valid |-> (o_month != 4'd2 || o_day <= 5'd29) && ((o_month != 4'd4 && o_month != 4'd6 && o_month != 4'd9 && o_month != 4'd11) || o_day <= 5'd30))

    // reset drops any pending result
    `E2U_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind epoch_to_utc_date e2u_checker u_e2u_checker (.*);
